>>> hdl/gss_pkg.sv
// Shared types and constants for the grid step sequencer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package gss_pkg;

    localparam int COLUMNS     = 64;
    localparam int ROWS        = 16;
    localparam int MAX_RESULTS = 64;

    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int CNT_W   = $clog2(ROWS + 1);
    localparam int NRES_W  = $clog2(MAX_RESULTS + 1);
    localparam int POS_W   = 9;
    localparam int IDX_W   = 7;
    localparam int RANK_W  = 6;
    localparam int OFF_W   = 16;
    localparam int BEAT_W  = 32;
    localparam int CLK_W   = 32;
    localparam int BPS_W   = 24;
    localparam int TIME_W  = 48;
    localparam int OP_W    = 3;
    localparam int KIND_W  = 2;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 24;
    localparam int LOOP_W  = 6;
    localparam int AROW_W  = 5;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
    localparam logic [OP_W-1:0] OP_SETPOS = 3'd5;
    localparam logic [OP_W-1:0] OP_RESYNC = 3'd6;

    localparam logic [KIND_W-1:0] KIND_TRIG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic [CIDX_W-1:0] REG_LOOP_START = 3'd0;
    localparam logic [CIDX_W-1:0] REG_LOOP_END   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_BPS        = 3'd2;
    localparam logic [CIDX_W-1:0] REG_PLAYING    = 3'd3;
    localparam logic [CIDX_W-1:0] REG_ACT_ROWS   = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [OFF_W-1:0] off;
    } cell_t;

    typedef cell_t [ROWS-1:0] column_t;

    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_TRIG,
        PUSH_REPORT,
        PUSH_QUERY
    } push_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_MEM_RD,
        S_MEM_CAP,
        S_MEM_WR,
        S_QUERY,
        S_LOAD,
        S_LOAD_CAP,
        S_RANK,
        S_EVAL,
        S_REPORT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  tick_upd;
        logic  div_start;
        logic  mem_rd;
        logic  rd_pos;
        logic  mem_cap;
        logic  mem_wr;
        logic  clear_all;
        logic  set_pos;
        logic  resync_load;
        logic  walk_init;
        logic  load_skip;
        logic  rank_step;
        logic  eval_step;
        logic  report_step;
        push_t push;
        logic  flush;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            tick_quiet;
        logic            div_done;
        logic            pos_in;
        logic            rank_last;
        logic            walk_stop;
        logic            trig;
        logic            change;
        logic            can_push;
        logic            pend_valid;
        logic            out_free;
    } sts_t;

endpackage

>>> hdl/grid_step_sequencer.sv
// Top level of the grid step sequencer: controller plus datapath.
// Depends on gss_pkg, gss_ctrl and gss_datapath.
//
//   channel   dir  handshake            payload
//   s_        in   s_valid / s_ready    op, beat_pos, transport_on, column, row, offset, position
//   m_        out  m_valid / m_ready    kind, row_res, column_res, step_time, found, offset_res, last
//   cfg_      in   cfg_wr_en            cfg_index, cfg_data
//
// One item is worked at a time. A walking tick first runs the bit-serial divider, then
// for each column visited reads the memory and ranks every row, then evaluates its cells.
// Reset is synchronous, active low; the cell store is empty right after reset.
// A stalled m_ side holds the walk; results are staged so the last one is marked.
`timescale 1ns / 1ps

module grid_step_sequencer import gss_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_op,
    input  logic [BEAT_W-1:0]  s_beat_pos,
    input  logic               s_transport_on,
    input  logic [COL_W-1:0]   s_column,
    input  logic [ROW_W-1:0]   s_row,
    input  logic [OFF_W-1:0]   s_offset,
    input  logic signed [7:0]  s_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KIND_W-1:0]  m_kind,
    output logic [ROW_W-1:0]   m_row_res,
    output logic [COL_W-1:0]   m_column_res,
    output logic [TIME_W-1:0]  m_step_time,
    output logic               m_found,
    output logic [OFF_W-1:0]   m_offset_res,
    output logic               m_last,
    input  logic               cfg_wr_en,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    gss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gss_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_op           (s_op),
        .s_beat_pos     (s_beat_pos),
        .s_transport_on (s_transport_on),
        .s_column       (s_column),
        .s_row          (s_row),
        .s_offset       (s_offset),
        .s_position     (s_position),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_row_res      (m_row_res),
        .m_column_res   (m_column_res),
        .m_step_time    (m_step_time),
        .m_found        (m_found),
        .m_offset_res   (m_offset_res),
        .m_last         (m_last)
    );

endmodule

>>> hdl/gss_divider.sv
// Restoring divider, one quotient bit per cycle: (beats << 16) / beats_per_step.
// Depends on gss_pkg; a zero divisor gives all ones.
`timescale 1ns / 1ps

module gss_divider import gss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [BPS_W-1:0]  divisor,
    output logic              done,
    output logic [TIME_W-1:0] quotient
);

    localparam int DCNT_W = $clog2(TIME_W);

    logic [TIME_W-1:0] q_reg;
    logic [BPS_W-1:0]  rem_reg;
    logic [BPS_W-1:0]  d_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [BPS_W:0] shifted;
    logic [BPS_W:0] diff;
    logic           ge;

    assign shifted = {rem_reg, q_reg[TIME_W-1]};
    assign ge      = shifted >= {1'b0, d_reg};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= '0;
                if (divisor == '0) begin
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(TIME_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= (divisor == '0) ? '1 : dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[TIME_W-2:0], ge};
            rem_reg <= ge ? diff[BPS_W-1:0] : shifted[BPS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> hdl/gss_datapath.sv
// Datapath: configuration, playhead state, cell memory, column rank table,
// result staging and output register. Depends on gss_pkg and gss_divider.
`timescale 1ns / 1ps

module gss_datapath import gss_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [OP_W-1:0]    s_op,
    input  logic [BEAT_W-1:0]  s_beat_pos,
    input  logic               s_transport_on,
    input  logic [COL_W-1:0]   s_column,
    input  logic [ROW_W-1:0]   s_row,
    input  logic [OFF_W-1:0]   s_offset,
    input  logic signed [7:0]  s_position,
    input  logic               cfg_wr_en,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KIND_W-1:0]  m_kind,
    output logic [ROW_W-1:0]   m_row_res,
    output logic [COL_W-1:0]   m_column_res,
    output logic [TIME_W-1:0]  m_step_time,
    output logic               m_found,
    output logic [OFF_W-1:0]   m_offset_res,
    output logic               m_last
);

    // captured input item
    logic [OP_W-1:0]   op_reg;
    logic [BEAT_W-1:0] beats_reg;
    logic              tr_reg;
    logic [COL_W-1:0]  col_in_reg;
    logic [ROW_W-1:0]  row_in_reg;
    logic [OFF_W-1:0]  off_in_reg;
    logic signed [7:0] posreq_reg;

    // configuration
    logic [LOOP_W-1:0] loop_start_reg;
    logic [LOOP_W-1:0] loop_end_reg;
    logic [BPS_W-1:0]  bps_reg;
    logic              playing_reg;
    logic [AROW_W-1:0] active_rows_reg;

    // playhead
    logic [CLK_W-1:0]         step_clock_reg;
    logic [IDX_W-1:0]         step_index_reg;
    logic signed [RANK_W-1:0] cursor_rank_reg;
    logic [OFF_W-1:0]         held_offset_reg;
    logic [1:0]               warm_reg;
    logic                     last_tr_reg;
    logic                     fix_reg;
    logic [NRES_W-1:0]        n_reg;

    // cell memory, one word per column
    column_t           mem [COLUMNS];
    logic [COLUMNS-1:0] colv_reg;
    column_t           rd_data_reg;
    logic              rd_colv_reg;
    column_t           col_reg;
    logic [ROW_W-1:0]  rnk_reg [ROWS];
    logic [ROW_W-1:0]  rcnt_reg;

    // result staging
    logic              pend_valid_reg;
    logic [KIND_W-1:0] pend_kind_reg;
    logic [ROW_W-1:0]  pend_row_reg;
    logic [COL_W-1:0]  pend_col_reg;
    logic [TIME_W-1:0] pend_time_reg;
    logic              pend_found_reg;
    logic [OFF_W-1:0]  pend_off_reg;

    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic              out_found_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic              out_last_reg;

    logic              div_done;
    logic [TIME_W-1:0] div_q;

    gss_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({beats_reg, 16'h0000}),
        .divisor  (bps_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- combinational walk terms ----------------
    logic                     dir_back;
    logic signed [POS_W-1:0]  s9, e9, pos, newpos;
    logic [IDX_W-1:0]         idx_inc;
    logic                     pos_in;
    logic [CNT_W-1:0]         cnt;
    logic [ROWS-1:0]          match;
    logic                     has;
    logic [ROW_W-1:0]         hit_row;
    logic [OFF_W-1:0]         hit_off;
    logic                     change;
    logic                     trig;
    logic [1:0]               need;
    logic [NRES_W:0]          n_sum;
    logic [TIME_W-1:0]        now;
    logic                     wrap_idx;
    logic signed [RANK_W-1:0] rank_adv;
    logic [CNT_W-1:0]         smaller;
    logic [OFF_W-1:0]         off_r;
    logic signed [POS_W-1:0]  pclamp;
    logic signed [POS_W-1:0]  idx_set;
    cell_t                    qcell;
    column_t                  col_mod;
    logic                     push;
    logic                     move_out;
    logic [ROW_W-1:0]         new_row;
    logic [KIND_W-1:0]        new_kind;
    logic [TIME_W-1:0]        new_time;
    logic                     new_found;
    logic [OFF_W-1:0]         new_off;
    logic                     cfg_loop_ok;
    logic [COL_W-1:0]         rd_addr;

    assign dir_back = loop_end_reg < loop_start_reg;
    assign s9       = $signed({{(POS_W-LOOP_W){1'b0}}, loop_start_reg});
    assign e9       = $signed({{(POS_W-LOOP_W){1'b0}}, loop_end_reg});
    assign idx_inc  = step_index_reg + 1'b1;

    always_comb begin
        if (dir_back) begin
            pos    = s9 - $signed({{(POS_W-IDX_W){1'b0}}, step_index_reg});
            newpos = s9 - $signed({{(POS_W-IDX_W){1'b0}}, idx_inc});
        end else begin
            pos    = s9 + $signed({{(POS_W-IDX_W){1'b0}}, step_index_reg});
            newpos = s9 + $signed({{(POS_W-IDX_W){1'b0}}, idx_inc});
        end
    end

    assign pos_in = !pos[POS_W-1] && (pos < $signed(POS_W'(COLUMNS)));

    always_comb begin
        cnt = '0;
        for (int r = 0; r < ROWS; r++) begin
            cnt = cnt + CNT_W'(col_reg[r].valid);
        end
    end

    always_comb begin
        has     = 1'b0;
        hit_row = '0;
        hit_off = '0;
        for (int r = 0; r < ROWS; r++) begin
            match[r] = col_reg[r].valid && !cursor_rank_reg[RANK_W-1]
                       && ({{(RANK_W-ROW_W){1'b0}}, rnk_reg[r]} == cursor_rank_reg);
            if (match[r]) begin
                has     = 1'b1;
                hit_row = ROW_W'(r);
                hit_off = col_reg[r].off;
            end
        end
    end

    always_comb begin
        if (dir_back) begin
            change = (cnt == '0) || (cursor_rank_reg < RANK_W'(1));
            rank_adv = cursor_rank_reg[RANK_W-1] ? cursor_rank_reg : cursor_rank_reg - 1'b1;
            // hold at minus one
            if (cursor_rank_reg == '1) begin
                rank_adv = '1;
            end
            wrap_idx = (newpos < e9) || (newpos > s9);
        end else begin
            change = (cnt == '0)
                     || ($signed({cursor_rank_reg[RANK_W-1], cursor_rank_reg}) + 1
                         >= $signed({{(RANK_W+1-CNT_W){1'b0}}, cnt}));
            rank_adv = cursor_rank_reg + 1'b1;
            wrap_idx = (newpos > e9) || (newpos < s9);
        end
    end

    assign trig  = has && ({1'b0, hit_row} < active_rows_reg) && playing_reg;
    assign need  = {1'b0, trig} + {1'b0, change};
    assign n_sum = {1'b0, n_reg} + (NRES_W+1)'(need);
    assign now   = {step_clock_reg, held_offset_reg};

    // rank of one cell per cycle against all cells of the column
    assign off_r = col_reg[rcnt_reg].off;
    always_comb begin
        smaller = '0;
        for (int q = 0; q < ROWS; q++) begin
            if (col_reg[q].valid
                && ({col_reg[q].off, ROW_W'(q)} < {off_r, rcnt_reg})) begin
                smaller = smaller + 1'b1;
            end
        end
    end

    // clamp requested position to the loop range
    always_comb begin
        pclamp = $signed({posreq_reg[7], posreq_reg});
        if (dir_back) begin
            if (pclamp < e9) pclamp = e9;
            if (pclamp > s9) pclamp = s9;
            idx_set = s9 - pclamp;
        end else begin
            if (pclamp > e9) pclamp = e9;
            if (pclamp < s9) pclamp = s9;
            idx_set = pclamp - s9;
        end
    end

    assign qcell = col_reg[row_in_reg];

    always_comb begin
        col_mod = col_reg;
        if (op_reg == OP_SET) begin
            col_mod[row_in_reg] = '{valid: 1'b1, off: off_in_reg};
        end else begin
            col_mod[row_in_reg] = '0;
        end
    end

    assign rd_addr = cmd.rd_pos ? pos[COL_W-1:0] : col_in_reg;

    assign cfg_loop_ok = (cfg_data[LOOP_W-1:0] != loop_start_reg)
                         && (cfg_data[LOOP_W-1:0] != loop_end_reg);

    // ---------------- capture and configuration ----------------
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_op;
            beats_reg  <= s_beat_pos;
            tr_reg     <= s_transport_on;
            col_in_reg <= s_column;
            row_in_reg <= s_row;
            off_in_reg <= s_offset;
            posreq_reg <= s_position;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_start_reg  <= '0;
            loop_end_reg    <= LOOP_W'(15);
            bps_reg         <= BPS_W'(32768);
            playing_reg     <= 1'b1;
            active_rows_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LOOP_START: if (cfg_loop_ok) loop_start_reg <= cfg_data[LOOP_W-1:0];
                REG_LOOP_END:   if (cfg_loop_ok) loop_end_reg <= cfg_data[LOOP_W-1:0];
                REG_BPS:        bps_reg <= cfg_data[BPS_W-1:0];
                REG_PLAYING:    playing_reg <= cfg_data[0];
                REG_ACT_ROWS:   active_rows_reg <= cfg_data[AROW_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- playhead ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_clock_reg  <= '0;
            step_index_reg  <= '0;
            cursor_rank_reg <= '0;
            held_offset_reg <= '0;
            warm_reg        <= '0;
            last_tr_reg     <= 1'b0;
            fix_reg         <= 1'b0;
            n_reg           <= '0;
        end else begin
            if (cfg_wr_en && cfg_loop_ok
                && (cfg_index == REG_LOOP_START || cfg_index == REG_LOOP_END)) begin
                cursor_rank_reg <= '0;
                held_offset_reg <= '0;
            end
            if (cmd.tick_upd) begin
                last_tr_reg <= tr_reg;
                if (last_tr_reg && !tr_reg) begin
                    step_clock_reg  <= '0;
                    step_index_reg  <= '0;
                    held_offset_reg <= '0;
                    warm_reg        <= '0;
                end else if (warm_reg < 2'd2) begin
                    warm_reg <= warm_reg + 1'b1;
                end
            end
            if (cmd.set_pos) begin
                step_index_reg  <= idx_set[IDX_W-1:0];
                cursor_rank_reg <= '0;
                held_offset_reg <= '0;
            end
            if (cmd.resync_load) begin
                step_clock_reg <= div_q[TIME_W-1:OFF_W];
            end
            if (cmd.walk_init) begin
                n_reg   <= '0;
                fix_reg <= 1'b0;
            end
            if (cmd.load_skip) begin
                fix_reg <= 1'b0;
            end
            if (cmd.rank_step && rcnt_reg == ROW_W'(ROWS - 1) && fix_reg) begin
                fix_reg <= 1'b0;
                if (cnt != '0) begin
                    cursor_rank_reg <= RANK_W'(cnt - 1'b1);
                end
            end
            if (cmd.eval_step) begin
                held_offset_reg <= has ? hit_off : '0;
                cursor_rank_reg <= rank_adv;
                n_reg           <= n_reg + NRES_W'(trig);
            end
            if (cmd.report_step) begin
                n_reg          <= n_reg + 1'b1;
                step_index_reg <= wrap_idx ? '0 : idx_inc;
                step_clock_reg <= step_clock_reg + 1'b1;
                if (dir_back) begin
                    fix_reg <= 1'b1;
                end else begin
                    cursor_rank_reg <= '0;
                end
            end
        end
    end

    // ---------------- cell memory ----------------
    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[col_in_reg] <= col_mod;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colv_reg    <= '0;
            rd_colv_reg <= 1'b0;
        end else begin
            if (cmd.clear_all) begin
                colv_reg <= '0;
            end else if (cmd.mem_wr) begin
                colv_reg[col_in_reg] <= 1'b1;
            end
            if (cmd.mem_rd) begin
                rd_colv_reg <= colv_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_cap) begin
            col_reg  <= rd_colv_reg ? rd_data_reg : '0;
            rcnt_reg <= '0;
        end else if (cmd.load_skip) begin
            col_reg <= '0;
        end else if (cmd.rank_step) begin
            rnk_reg[rcnt_reg] <= smaller[ROW_W-1:0];
            rcnt_reg          <= rcnt_reg + 1'b1;
        end
    end

    // ---------------- result staging ----------------
    assign push     = cmd.push != PUSH_NONE;
    assign move_out = (push && pend_valid_reg) || cmd.flush;

    always_comb begin
        new_kind  = KIND_TRIG;
        new_row   = '0;
        new_time  = '0;
        new_found = 1'b0;
        new_off   = '0;
        unique case (cmd.push)
            PUSH_TRIG: begin
                new_row  = hit_row;
                new_time = now;
            end
            PUSH_REPORT: new_kind = KIND_REPORT;
            PUSH_QUERY: begin
                new_kind  = KIND_QUERY;
                new_found = qcell.valid;
                new_off   = qcell.valid ? qcell.off : '0;
            end
            PUSH_NONE: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (push) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (move_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            pend_kind_reg  <= new_kind;
            pend_row_reg   <= new_row;
            pend_col_reg   <= pos[COL_W-1:0];
            pend_time_reg  <= new_time;
            pend_found_reg <= new_found;
            pend_off_reg   <= new_off;
        end
        if (move_out) begin
            out_kind_reg  <= pend_kind_reg;
            out_row_reg   <= pend_row_reg;
            out_col_reg   <= pend_col_reg;
            out_time_reg  <= pend_time_reg;
            out_found_reg <= pend_found_reg;
            out_off_reg   <= pend_off_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    // ---------------- status ----------------
    always_comb begin
        sts.op         = op_reg;
        sts.tick_quiet = (last_tr_reg && !tr_reg) || (warm_reg < 2'd2);
        sts.div_done   = div_done;
        sts.pos_in     = pos_in;
        sts.rank_last  = rcnt_reg == ROW_W'(ROWS - 1);
        sts.walk_stop  = (now >= div_q) || (n_sum > (NRES_W+1)'(MAX_RESULTS));
        sts.trig       = trig;
        sts.change     = change;
        sts.out_free   = !out_valid_reg || m_ready;
        sts.can_push   = !pend_valid_reg || !out_valid_reg || m_ready;
        sts.pend_valid = pend_valid_reg;
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_kind_reg;
    assign m_row_res    = out_row_reg;
    assign m_column_res = out_col_reg;
    assign m_step_time  = out_time_reg;
    assign m_found      = out_found_reg;
    assign m_offset_res = out_off_reg;
    assign m_last       = out_last_reg;

endmodule

>>> hdl/gss_ctrl.sv
// Controller state machine: decodes each item and sequences the datapath.
// Depends on gss_pkg for the state, command and status types.
`timescale 1ns / 1ps

module gss_ctrl import gss_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_DECODE;
            S_DECODE: begin
                unique case (sts.op)
                    OP_TICK:   state_next = sts.tick_quiet ? S_FINISH : S_DIV;
                    OP_SET,
                    OP_DELETE,
                    OP_QUERY:  state_next = S_MEM_RD;
                    OP_RESYNC: state_next = S_DIV;
                    default:   state_next = S_FINISH;
                endcase
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = (sts.op == OP_RESYNC) ? S_FINISH : S_LOAD;
                end
            end
            S_MEM_RD:  state_next = S_MEM_CAP;
            S_MEM_CAP: state_next = (sts.op == OP_QUERY) ? S_QUERY : S_MEM_WR;
            S_MEM_WR:  state_next = S_FINISH;
            S_QUERY:   if (sts.can_push) state_next = S_FINISH;
            S_LOAD:    state_next = sts.pos_in ? S_LOAD_CAP : S_EVAL;
            S_LOAD_CAP: state_next = S_RANK;
            S_RANK:    if (sts.rank_last) state_next = S_EVAL;
            S_EVAL: begin
                priority if (sts.walk_stop) begin
                    state_next = S_FINISH;
                end else if (sts.trig && !sts.can_push) begin
                    state_next = S_EVAL;
                end else if (sts.change) begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:  if (sts.can_push) state_next = S_LOAD;
            S_FINISH:  if (!sts.pend_valid || sts.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.push = PUSH_NONE;
        s_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_DECODE: begin
                unique case (sts.op)
                    OP_TICK: begin
                        cmd.tick_upd  = 1'b1;
                        cmd.div_start = !sts.tick_quiet;
                    end
                    OP_CLEAR:  cmd.clear_all = 1'b1;
                    OP_SETPOS: cmd.set_pos = 1'b1;
                    OP_RESYNC: cmd.div_start = 1'b1;
                    default: ;
                endcase
            end
            S_DIV: begin
                cmd.resync_load = sts.div_done && (sts.op == OP_RESYNC);
                cmd.walk_init   = sts.div_done && (sts.op != OP_RESYNC);
            end
            S_MEM_RD:  cmd.mem_rd = 1'b1;
            S_MEM_CAP: cmd.mem_cap = 1'b1;
            S_MEM_WR:  cmd.mem_wr = 1'b1;
            S_QUERY: begin
                if (sts.can_push) cmd.push = PUSH_QUERY;
            end
            S_LOAD: begin
                cmd.rd_pos    = 1'b1;
                cmd.mem_rd    = sts.pos_in;
                cmd.load_skip = !sts.pos_in;
            end
            S_LOAD_CAP: cmd.mem_cap = 1'b1;
            S_RANK:     cmd.rank_step = 1'b1;
            S_EVAL: begin
                if (!sts.walk_stop && (!sts.trig || sts.can_push)) begin
                    cmd.eval_step = 1'b1;
                    if (sts.trig) cmd.push = PUSH_TRIG;
                end
            end
            S_REPORT: begin
                if (sts.can_push) begin
                    cmd.report_step = 1'b1;
                    cmd.push        = PUSH_REPORT;
                end
            end
            S_FINISH: cmd.flush = sts.pend_valid && sts.out_free;
            default: ;
        endcase
    end

endmodule

>>> hdl/gss_checker.sv
// Port-level checks on the result channel of the grid step sequencer.
// Depends on gss_pkg; bound to grid_step_sequencer below.
`timescale 1ns / 1ps

module gss_checker import gss_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [KIND_W-1:0] m_kind,
    input logic [ROW_W-1:0]  m_row_res,
    input logic [TIME_W-1:0] m_step_time,
    input logic              m_found,
    input logic [OFF_W-1:0]  m_offset_res,
    input logic              m_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_last))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_query_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_QUERY |-> m_last)
        else $error("query answer not marked last");

    a_non_trig: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_TRIG |-> m_step_time == '0 && m_row_res == '0)
        else $error("time or row on a non-trigger result");

    a_non_query: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_QUERY |-> !m_found && m_offset_res == '0)
        else $error("query fields on a non-query result");

endmodule

bind grid_step_sequencer gss_checker u_gss_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_row_res    (m_row_res),
    .m_step_time  (m_step_time),
    .m_found      (m_found),
    .m_offset_res (m_offset_res),
    .m_last       (m_last)
);
